// ===== sv/spff_pkg.sv =====
package spff_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned MAX_VALUE_DEFAULT = 65536;
  localparam int unsigned TABLE_CAP = 65536;

endpackage

// ===== sv/smallest_prime_factor_factorizer_unit.sv =====
// After reset the factor table is built: a fill pass over every entry, then a sieve pass
// in which each sieve candidate takes a read state and a check state; busy stays high.
// Input 0, 1, or a value not below the table size gives its one result the cycle after start.
// Otherwise each factor takes a table read plus a one-bit-per-cycle divider, and the
// factors of a number come one after another; busy is high throughout.
// Each result is shown for exactly one cycle with valid high; the receiver cannot stall.
module smallest_prime_factor_factorizer_unit #(
  parameter int unsigned MAX_VALUE = spff_pkg::MAX_VALUE_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [spff_pkg::DATA_W-1:0] number,
  output logic                        valid,
  output logic [spff_pkg::DATA_W-1:0] factor,
  output logic                        last
);

  localparam int unsigned TABLE_SIZE =
    (MAX_VALUE < spff_pkg::TABLE_CAP) ? MAX_VALUE : spff_pkg::TABLE_CAP;
  localparam int unsigned ADDR_W = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W = ADDR_W + 1;
  localparam logic [CNT_W-1:0] TSIZE = CNT_W'(TABLE_SIZE);
  localparam logic [spff_pkg::DATA_W:0] TSIZE_IN = (spff_pkg::DATA_W + 1)'(TABLE_SIZE);

  typedef enum logic [2:0] {
    S_INIT,
    S_PRIME_RD,
    S_PRIME_CHK,
    S_MARK_RD,
    S_MARK_CHK,
    S_IDLE,
    S_LOOK,
    S_DIV
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] table_mem [TABLE_SIZE];
  logic [ADDR_W-1:0] rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] wr_data;

  logic [CNT_W-1:0]  p;
  logic [CNT_W-1:0]  psq;
  logic [CNT_W-1:0]  m;
  logic [ADDR_W-1:0] rem;
  logic [ADDR_W-1:0] fac;
  logic              div_wait;

  logic [CNT_W-1:0]  p_next;
  logic [CNT_W-1:0]  psq_next;
  logic [CNT_W-1:0]  m_next;
  logic              div_go;
  logic              div_done;
  logic [ADDR_W-1:0] quotient;

  always_comb begin
    p_next   = CNT_W'(p + 1'b1);
    psq_next = CNT_W'(psq + {p[CNT_W-2:0], 1'b1});
    m_next   = CNT_W'(m + p);
  end

  always_comb begin
    case (state)
      S_PRIME_RD: rd_addr = p[ADDR_W-1:0];
      S_MARK_RD:  rd_addr = m[ADDR_W-1:0];
      default:    rd_addr = rem;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = m[ADDR_W-1:0];
    wr_data = m[ADDR_W-1:0];
    case (state)
      S_INIT: begin
        we = 1'b1;
        if (m < CNT_W'(2)) begin
          wr_data = '0;
        end
      end
      S_MARK_CHK: begin
        we      = (rdata == m[ADDR_W-1:0]);
        wr_data = p[ADDR_W-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[wr_addr] <= wr_data;
    end
    rdata <= table_mem[rd_addr];
  end

  assign div_go = (state == S_LOOK) && div_wait;

  spff_div #(
    .W (ADDR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (rem),
    .divisor  (rdata),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      p        <= CNT_W'(2);
      psq      <= CNT_W'(4);
      m        <= '0;
      rem      <= '0;
      div_wait <= 1'b0;
      valid    <= 1'b0;
      last     <= 1'b0;
      factor   <= '0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_INIT: begin
          m <= m_next - p + CNT_W'(1);
          if (m == TSIZE - CNT_W'(1)) begin
            state <= (psq < TSIZE) ? S_PRIME_RD : S_IDLE;
          end
        end
        S_PRIME_RD: begin
          state <= S_PRIME_CHK;
        end
        S_PRIME_CHK: begin
          if (rdata == p[ADDR_W-1:0]) begin
            m     <= psq;
            state <= S_MARK_RD;
          end else begin
            p     <= p_next;
            psq   <= psq_next;
            state <= (psq_next < TSIZE) ? S_PRIME_RD : S_IDLE;
          end
        end
        S_MARK_RD: begin
          state <= S_MARK_CHK;
        end
        S_MARK_CHK: begin
          m <= m_next;
          if (m_next >= TSIZE) begin
            p     <= p_next;
            psq   <= psq_next;
            state <= (psq_next < TSIZE) ? S_PRIME_RD : S_IDLE;
          end else begin
            state <= S_MARK_RD;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (number < spff_pkg::DATA_W'(2) || {1'b0, number} >= TSIZE_IN) begin
              valid  <= 1'b1;
              factor <= '0;
              last   <= 1'b1;
              rem    <= '0;
            end else begin
              rem      <= number[ADDR_W-1:0];
              div_wait <= 1'b0;
              state    <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (div_wait) begin
            fac   <= rdata;
            state <= S_DIV;
          end else begin
            div_wait <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rem      <= quotient;
            valid    <= 1'b1;
            factor   <= spff_pkg::DATA_W'(fac);
            last     <= (quotient <= ADDR_W'(1));
            div_wait <= 1'b0;
            state    <= (quotient <= ADDR_W'(1)) ? S_IDLE : S_LOOK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== sv/spff_div.sv =====
module spff_div #(
  parameter int unsigned W = spff_pkg::DATA_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             running;
  logic [CNT_W-1:0] count;
  logic [W-1:0]     acc;
  logic [W-1:0]     quo;
  logic [W-1:0]     dsr;
  logic [W:0]       shifted;
  logic             fits;
  logic [W-1:0]     acc_next;
  logic [W-1:0]     quo_next;

  always_comb begin
    shifted  = {acc, quo[W-1]};
    fits     = (shifted >= {1'b0, dsr});
    acc_next = fits ? W'(shifted - {1'b0, dsr}) : shifted[W-1:0];
    quo_next = {quo[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        count   <= '0;
        acc     <= '0;
        quo     <= dividend;
        dsr     <= divisor;
      end else if (running) begin
        acc   <= acc_next;
        quo   <= quo_next;
        count <= CNT_W'(count + 1'b1);
        if (count == CNT_W'(W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule
